FILE: hdl/psem_pkg.sv
// ============================================================================
// psem_pkg
// Shared types and codes for the priority counting semaphore.
// ============================================================================
package psem_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int PRIO_W   = 6;
    localparam int CFG_W    = 16;

    localparam logic [OP_W-1:0] OP_DOWN     = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY_DOWN = 2'd1;
    localparam logic [OP_W-1:0] OP_UP       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRY_FAILED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WOKEN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RAISED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: hdl/priority_counting_semaphore_top.sv
// A word's result is registered and shown in the cycle after the word is accepted.
// Throughput: one word per cycle; the queue chain inserts or pops in a single step.
// A held result stalls the input only while the output is stalled.
// Reset: count and waiter total clear, output empties; queue slots are not cleared.
// A configuration write reloads the count (saturated) and empties the queue.
// ============================================================================
// priority_counting_semaphore_top
// Counting semaphore with a priority-sorted wait queue built as a cell chain.
// ============================================================================
module priority_counting_semaphore_top
    import psem_pkg::*;
#(
    parameter int MAX_WAITERS    = 16,
    parameter int COUNT_BITS     = 16,
    parameter int THREAD_ID_BITS = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [CFG_W-1:0]                     cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [OP_W-1:0]                      opcode,
    input  logic [THREAD_ID_BITS-1:0]            thread_id,
    input  logic [PRIO_W-1:0]                    priority_req,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [STATUS_W-1:0]                  status,
    output logic [THREAD_ID_BITS-1:0]            woken_thread,
    output logic [COUNT_BITS-1:0]                count_now,
    output logic [$clog2(MAX_WAITERS+1)-1:0]     waiting_now
);

    localparam int TW = $clog2(MAX_WAITERS + 1);
    localparam int CW = (CFG_W > COUNT_BITS) ? CFG_W : COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_WAITERS);

    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     count_next;
    logic [TW-1:0]             total_reg;
    logic [TW-1:0]             total_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [THREAD_ID_BITS-1:0] woken_reg;
    logic [THREAD_ID_BITS-1:0] woken_next;

    logic                      acc;
    logic [CW-1:0]             cfg_ext;
    logic [COUNT_BITS-1:0]     cfg_sat;
    cell_ctrl_t                ctrl;

    logic [MAX_WAITERS-1:0]    occ;
    logic [MAX_WAITERS-1:0]    keep;
    logic [THREAD_ID_BITS-1:0] cell_id   [MAX_WAITERS];
    logic [PRIO_W-1:0]         cell_prio [MAX_WAITERS];

    assign in_stall = out_valid_reg && out_stall;
    assign acc      = in_valid && !in_stall;

    assign cfg_ext = CW'(cfg_wr_data);
    assign cfg_sat = (cfg_ext > CW'(COUNT_MAX)) ? COUNT_MAX : cfg_ext[COUNT_BITS-1:0];

    always_comb
    begin
        count_next  = count_reg;
        total_next  = total_reg;
        status_next = status_reg;
        woken_next  = woken_reg;
        ctrl.push   = 1'b0;
        ctrl.pop    = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        if (acc)
        begin
            out_valid_next = 1'b1;
            woken_next     = '0;
            unique case (opcode)
                OP_DOWN, OP_TRY_DOWN:
                begin
                    priority if (count_reg != '0)
                    begin
                        count_next  = count_reg - COUNT_BITS'(1);
                        status_next = ST_GRANTED;
                    end
                    else if (opcode == OP_TRY_DOWN)
                    begin
                        status_next = ST_TRY_FAILED;
                    end
                    else if (total_reg == TOTAL_MAX)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push   = 1'b1;
                        total_next  = total_reg + TW'(1);
                        status_next = ST_QUEUED;
                    end
                end
                OP_UP:
                begin
                    if (total_reg != '0)
                    begin
                        ctrl.pop    = 1'b1;
                        total_next  = total_reg - TW'(1);
                        woken_next  = cell_id[0];
                        status_next = ST_WOKEN;
                    end
                    else
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                        status_next = ST_RAISED;
                    end
                end
                default:
                begin
                    status_next = ST_TRY_FAILED;
                end
            endcase
        end
        if (cfg_wr_en)
        begin
            count_next = cfg_sat;
            total_next = '0;
            ctrl.push  = 1'b0;
            ctrl.pop   = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WAITERS; gi++)
        begin : g_cell
            logic                      lk;
            logic [THREAD_ID_BITS-1:0] lid;
            logic [PRIO_W-1:0]         lprio;
            logic [THREAD_ID_BITS-1:0] rid;
            logic [PRIO_W-1:0]         rprio;

            assign occ[gi] = total_reg > TW'(gi);

            if (gi == 0)
            begin : g_first
                assign lk    = 1'b1;
                assign lid   = thread_id;
                assign lprio = priority_req;
            end
            else
            begin : g_mid
                assign lk    = keep[gi-1];
                assign lid   = cell_id[gi-1];
                assign lprio = cell_prio[gi-1];
            end

            if (gi == MAX_WAITERS - 1)
            begin : g_last
                assign rid   = thread_id;
                assign rprio = priority_req;
            end
            else
            begin : g_inner
                assign rid   = cell_id[gi+1];
                assign rprio = cell_prio[gi+1];
            end

            psem_cell #(
                .ID_W (THREAD_ID_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ[gi]),
                .new_id     (thread_id),
                .new_prio   (priority_req),
                .left_keep  (lk),
                .left_id    (lid),
                .left_prio  (lprio),
                .right_id   (rid),
                .right_prio (rprio),
                .keep       (keep[gi]),
                .id         (cell_id[gi]),
                .prio       (cell_prio[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    logic [COUNT_BITS-1:0] count_out_reg;
    logic [TW-1:0]         total_out_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg    <= status_next;
            woken_reg     <= woken_next;
            count_out_reg <= count_next;
            total_out_reg <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign woken_thread = woken_reg;
    assign count_now    = count_out_reg;
    assign waiting_now  = total_out_reg;

endmodule

FILE: hdl/psem_cell.sv
// ============================================================================
// psem_cell
// One slot of the sorted wait queue: holds a thread id and its priority,
// shifts right on insert behind equal or higher priorities, shifts left on pop.
// ============================================================================
module psem_cell
    import psem_pkg::*;
#(
    parameter int ID_W = 8
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              occ,
    input  logic [ID_W-1:0]   new_id,
    input  logic [PRIO_W-1:0] new_prio,
    input  logic              left_keep,
    input  logic [ID_W-1:0]   left_id,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [ID_W-1:0]   right_id,
    input  logic [PRIO_W-1:0] right_prio,
    output logic              keep,
    output logic [ID_W-1:0]   id,
    output logic [PRIO_W-1:0] prio
);

    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;

    assign keep = occ && (prio_reg >= new_prio);
    assign id   = id_reg;
    assign prio = prio_reg;

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        priority if (ctrl.push)
        begin
            priority if (keep)
            begin
                id_next   = id_reg;
                prio_next = prio_reg;
            end
            else if (left_keep)
            begin
                id_next   = new_id;
                prio_next = new_prio;
            end
            else
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
        end
        else if (ctrl.pop)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
        else
        begin
            id_next   = id_reg;
            prio_next = prio_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

FILE: hdl/psem_checker.sv
// ============================================================================
// psem_checker
// Port-level checks on the semaphore's result words.
// ============================================================================
module psem_checker
    import psem_pkg::*;
#(
    parameter int MAX_WAITERS    = 16,
    parameter int COUNT_BITS     = 16,
    parameter int THREAD_ID_BITS = 8
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [STATUS_W-1:0]              status,
    input logic [THREAD_ID_BITS-1:0]        woken_thread,
    input logic [COUNT_BITS-1:0]            count_now,
    input logic [$clog2(MAX_WAITERS+1)-1:0] waiting_now
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count_now)
            && $stable(waiting_now) && $stable(woken_thread))
        else $error("result word changed while stalled");

    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_WOKEN) |-> woken_thread == '0)
        else $error("woken thread set without a wake");

    a_queued_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_QUEUED) |-> (waiting_now != '0) && (count_now == '0))
        else $error("queued word with empty queue or free permits");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |->
            waiting_now == ($clog2(MAX_WAITERS+1))'(MAX_WAITERS))
        else $error("queue full reported below capacity");

endmodule

bind priority_counting_semaphore_top psem_checker #(
    .MAX_WAITERS    (MAX_WAITERS),
    .COUNT_BITS     (COUNT_BITS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
) u_psem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .woken_thread (woken_thread),
    .count_now    (count_now),
    .waiting_now  (waiting_now)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the priority counting semaphore. A directed table
// covers reset, the field extremes, saturation, the full queue and reloads;
// random phases follow with mixed start counts, opcode mixes and priority
// ranges. Each accepted word runs through an in-bench copy of the count and
// sorted wait queue. Results are compared field by field in order.
// ============================================================================
module tb;
    import psem_pkg::*;

    localparam int TID_W       = 8;
    localparam int CNT_W       = 16;
    localparam int QDEPTH      = 16;
    localparam int WAIT_W      = $clog2(QDEPTH + 1);
    localparam int LONG_HOLD   = 60;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 108;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    woken;
        logic [CNT_W-1:0]    count;
        logic [WAIT_W-1:0]   waiting;
    } sem_word_t;

    typedef struct packed {
        bit                  is_cfg;
        logic [CFG_W-1:0]    start_count;
        logic [OP_W-1:0]     op;
        logic [TID_W-1:0]    tid;
        logic [PRIO_W-1:0]   prio;
        int                  reps;
        bit                  typed;
        sem_word_t           want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     opcode;
    logic [TID_W-1:0]    thread_id;
    logic [PRIO_W-1:0]   priority_req;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    woken_thread;
    logic [CNT_W-1:0]    count_now;
    logic [WAIT_W-1:0]   waiting_now;

    bit                  word_typed;
    sem_word_t           word_want;
    bit                  tx_quiet;
    bit                  rx_quiet;
    bit                  hold_long;

    logic [CNT_W-1:0]    permits;
    logic [TID_W-1:0]    q_ids   [QDEPTH];
    logic [PRIO_W-1:0]   q_prios [QDEPTH];
    int                  q_len;

    sem_word_t           pending_results [$];
    dir_row_t            dir_rows [$];
    int                  mismatches;
    int                  words_in;
    int                  results_seen;
    int                  cfg_writes;
    int                  st_seen [8];

    priority_counting_semaphore_top #(
        .MAX_WAITERS    (QDEPTH),
        .COUNT_BITS     (CNT_W),
        .THREAD_ID_BITS (TID_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .woken_thread (woken_thread),
        .count_now    (count_now),
        .waiting_now  (waiting_now)
    );

    always #1 clk = ~clk;

    function automatic sem_word_t serve_request(input logic [OP_W-1:0] op,
                                                input logic [TID_W-1:0] tid,
                                                input logic [PRIO_W-1:0] prio);
        sem_word_t r;
        int        pos;
        int        k;
        r = '0;
        if (op == OP_DOWN || op == OP_TRY_DOWN)
        begin
            if (permits != '0)
            begin
                permits  = permits - 1'b1;
                r.status = ST_GRANTED;
            end
            else if (op == OP_TRY_DOWN)
                r.status = ST_TRY_FAILED;
            else if (q_len >= QDEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < q_len && q_prios[pos] >= prio)
                    pos++;
                for (k = q_len; k > pos; k--)
                begin
                    q_ids[k]   = q_ids[k-1];
                    q_prios[k] = q_prios[k-1];
                end
                q_ids[pos]   = tid;
                q_prios[pos] = prio;
                q_len++;
                r.status = ST_QUEUED;
            end
        end
        else if (op == OP_UP)
        begin
            if (q_len > 0)
            begin
                r.woken = q_ids[0];
                for (k = 1; k < q_len; k++)
                begin
                    q_ids[k-1]   = q_ids[k];
                    q_prios[k-1] = q_prios[k];
                end
                q_len--;
                r.status = ST_WOKEN;
            end
            else
            begin
                if (permits != '1)
                    permits = permits + 1'b1;
                r.status = ST_RAISED;
            end
        end
        else
            r.status = ST_TRY_FAILED;
        r.count   = permits;
        r.waiting = WAIT_W'(q_len);
        return r;
    endfunction

    always @(posedge clk)
    begin
        sem_word_t want;
        if (!rst_n)
        begin
            permits = '0;
            q_len   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                permits = cfg_wr_data;
                q_len   = 0;
                cfg_writes++;
            end
            if (in_valid && !in_stall)
            begin
                want = serve_request(opcode, thread_id, priority_req);
                if (word_typed)
                    want = word_want;
                pending_results.push_back(want);
                words_in++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                st_seen[status]++;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d", status);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (woken_thread !== want.woken)
                    begin
                        $error("woken_thread: expected %0d, got %0d", want.woken,
                               woken_thread);
                        mismatches++;
                    end
                    if (count_now !== want.count)
                    begin
                        $error("count_now: expected %0d, got %0d", want.count, count_now);
                        mismatches++;
                    end
                    if (waiting_now !== want.waiting)
                    begin
                        $error("waiting_now: expected %0d, got %0d", want.waiting,
                               waiting_now);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int stall_len;
        bit stall_on;
        out_stall = 1'b0;
        forever
        begin
            if (hold_long)
            begin
                stall_on  = 1'b1;
                stall_len = LONG_HOLD;
                hold_long = 1'b0;
            end
            else if (rx_quiet)
            begin
                stall_on  = 1'b0;
                stall_len = 1;
            end
            else
            begin
                stall_on  = ($urandom_range(0, 2) == 0);
                stall_len = $urandom_range(1, 14);
            end
            out_stall <= stall_on;
            repeat (stall_len) @(negedge clk);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    function automatic void add_row(input bit is_cfg, input logic [CFG_W-1:0] start_count,
                                    input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid,
                                    input logic [PRIO_W-1:0] prio, input int reps,
                                    input bit typed, input sem_word_t want);
        dir_row_t row;
        row.is_cfg      = is_cfg;
        row.start_count = start_count;
        row.op          = op;
        row.tid         = tid;
        row.prio        = prio;
        row.reps        = reps;
        row.typed       = typed;
        row.want        = want;
        dir_rows.push_back(row);
    endfunction

    // drop valid and hold until every result is back
    task automatic wait_drained();
        in_valid   <= 1'b0;
        word_typed <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_initial_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid,
                             input logic [PRIO_W-1:0] prio, input bit typed,
                             input sem_word_t want);
        int gap;
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        thread_id    <= tid;
        priority_req <= prio;
        word_typed   <= typed;
        word_want    <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int               i;
        int               ph;
        int               r;
        int               down_pct;
        int               prio_hi;
        logic [OP_W-1:0]  op;
        logic [CFG_W-1:0] start_count;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        opcode       = OP_DOWN;
        thread_id    = '0;
        priority_req = '0;
        word_typed   = 1'b0;
        word_want    = '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        hold_long    = 1'b0;
        mismatches   = 0;
        words_in     = 0;
        results_seen = 0;
        cfg_writes   = 0;
        for (i = 0; i < 8; i++)
            st_seen[i] = 0;

        add_row(0, '0, OP_TRY_DOWN, 8'h00, 6'h00, 1, 1, {ST_TRY_FAILED, 8'h00, 16'd0, 5'd0});
        add_row(0, '0, OP_UNUSED,   8'hFF, 6'h3F, 1, 1, {ST_TRY_FAILED, 8'h00, 16'd0, 5'd0});
        add_row(0, '0, OP_UP,       8'h12, 6'h00, 1, 1, {ST_RAISED, 8'h00, 16'd1, 5'd0});
        add_row(0, '0, OP_DOWN,     8'h34, 6'h15, 1, 1, {ST_GRANTED, 8'h00, 16'd0, 5'd0});
        add_row(0, '0, OP_DOWN,     8'hAA, 6'h00, 1, 1, {ST_QUEUED, 8'h00, 16'd0, 5'd1});
        add_row(0, '0, OP_DOWN,     8'h55, 6'h3F, 1, 1, {ST_QUEUED, 8'h00, 16'd0, 5'd2});
        add_row(0, '0, OP_DOWN,     8'h55, 6'h3F, 1, 0, '0);
        add_row(0, '0, OP_DOWN,     8'h01, 6'h20, 1, 0, '0);
        add_row(0, '0, OP_TRY_DOWN, 8'h02, 6'h3F, 1, 1, {ST_TRY_FAILED, 8'h00, 16'd0, 5'd4});
        add_row(0, '0, OP_UP,       8'h00, 6'h00, 1, 1, {ST_WOKEN, 8'h55, 16'd0, 5'd3});
        add_row(0, '0, OP_UP,       8'hC3, 6'h2A, 3, 0, '0);
        add_row(1, 16'hFFFF, OP_UP, 8'h00, 6'h00, 1, 0, '0);
        add_row(0, '0, OP_UP,       8'h7F, 6'h3F, 1, 1, {ST_RAISED, 8'h00, 16'hFFFF, 5'd0});
        add_row(0, '0, OP_TRY_DOWN, 8'h80, 6'h00, 1, 1, {ST_GRANTED, 8'h00, 16'hFFFE, 5'd0});
        add_row(1, 16'h0000, OP_UP, 8'h00, 6'h00, 1, 0, '0);
        add_row(0, '0, OP_DOWN,     8'h80, 6'h2A, QDEPTH, 0, '0);
        add_row(0, '0, OP_DOWN,     8'hFF, 6'h3F, 1, 1, {ST_FULL, 8'h00, 16'd0, 5'd16});
        add_row(0, '0, OP_UP,       8'h00, 6'h00, 1, 1, {ST_WOKEN, 8'h80, 16'd0, 5'd15});
        add_row(1, 16'h0005, OP_UP, 8'h00, 6'h00, 1, 0, '0);
        add_row(0, '0, OP_UP,       8'h00, 6'h00, 1, 1, {ST_RAISED, 8'h00, 16'd6, 5'd0});

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].is_cfg)
                write_initial_count(dir_rows[i].start_count);
            else
                repeat (dir_rows[i].reps)
                    send_word(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].prio,
                              dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin start_count = 16'd0;      down_pct = 65; end
                1:       begin start_count = 16'd0;      down_pct = 45; end
                2:       begin start_count = 16'd1;      down_pct = 50; end
                3:       begin start_count = 16'd0;      down_pct = 60; end
                4:       begin start_count = 16'hFFFF;   down_pct = 30; end
                5:       begin start_count = 16'd2;      down_pct = 50; end
                6:       begin start_count = 16'd0;      down_pct = 70; end
                7:       begin start_count = 16'hFFFE;   down_pct = 20; end
                8:       begin start_count = CFG_W'($urandom_range(0, 65535)); down_pct = 45; end
                9:       begin start_count = CFG_W'($urandom_range(0, 4));     down_pct = 50; end
                10:      begin start_count = 16'd0;      down_pct = 55; end
                default: begin start_count = 16'd3;      down_pct = 45; end
            endcase
            prio_hi  = (ph % 2 == 1) ? 3 : 63;
            tx_quiet = (ph == 5 || ph >= PHASES - 2);
            rx_quiet = tx_quiet;
            write_initial_count(start_count);
            // stall the output for a long stretch while words keep coming
            if (ph == 3)
            begin
                hold_long = 1'b1;
                tx_quiet  = 1'b1;
            end
            repeat (PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_UNUSED;
                else if (r < 15)
                    op = OP_TRY_DOWN;
                else if (r < 15 + down_pct)
                    op = OP_DOWN;
                else
                    op = OP_UP;
                send_word(op, TID_W'($urandom_range(0, 255)),
                          PRIO_W'($urandom_range(0, prio_hi)), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);

        $display("summary: %0d request words, %0d count reloads, %0d results checked",
                 words_in, cfg_writes, results_seen);
        $display("summary: granted %0d, queued %0d, try failed %0d, woken %0d, raised %0d, full %0d",
                 st_seen[ST_GRANTED], st_seen[ST_QUEUED], st_seen[ST_TRY_FAILED],
                 st_seen[ST_WOKEN], st_seen[ST_RAISED], st_seen[ST_FULL]);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/psem_pkg.sv
hdl/psem_cell.sv
hdl/priority_counting_semaphore_top.sv
hdl/psem_checker.sv
dv/tb.sv
